### hdl/bam_pkg.sv
package bam_pkg;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SUBJ   = 2'd2,
    REQ_PAD    = 2'd3
  } req_e;

  typedef enum logic {
    CFG_MAX_ERRORS = 1'b0,
    CFG_FIXED_MODE = 1'b1
  } cfg_idx_e;

  localparam int SymW   = 8;
  localparam int ErrW   = 3;
  localparam int StartW = 33;
  localparam int PosW   = 34;
  localparam int CountW = 32;

  localparam logic signed [PosW-1:0] PosMax   = 34'sd4294967295;
  localparam logic [CountW-1:0]      CountMax = '1;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic            shift_en;
    logic            restart;
    logic            step;
    logic            pad;
    logic            fixed_mode;
    logic [SymW-1:0] symbol;
  } bam_ctrl_t;

endpackage

### hdl/bam_cell.sv
module bam_cell import bam_pkg::*; #(
  parameter int J  = 0,
  parameter int NL = 8,
  parameter int SW = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bam_ctrl_t         ctrl_i,
  input  logic [SW-1:0]     size_i,
  input  logic [SW-1:0]     size_new_i,
  input  logic [SymW-1:0]   byte_i,
  output logic [SymW-1:0]   byte_o,
  input  logic [NL-1:0]     nb_mask_i,
  output logic [NL-1:0]     mask_o,
  output logic [NL-1:0]     mask_d_o
);

  logic [SymW-1:0] byte_q;
  logic [NL-1:0]   mask_q, mask_d, lv_new, lv_init, mask_rst;
  logic            in_use, miss, pm;

  assign in_use = J < int'(size_i);
  assign miss   = ctrl_i.fixed_mode ? (byte_q != ctrl_i.symbol)
                                    : ((byte_q & ctrl_i.symbol) == '0);
  assign pm     = ctrl_i.pad | (in_use & miss);

  for (genvar e = 0; e < NL; e++) begin : g_lvl
    if (e == 0) begin : g_first
      assign lv_new[e] = nb_mask_i[e] | pm;
    end else begin : g_next
      assign lv_new[e] = (nb_mask_i[e] | pm) & nb_mask_i[e-1] & lv_new[e-1];
    end
    assign lv_init[e]  = (size_new_i == '0) ? (J == 0 && e == 0)
                                            : ((J + e) < int'(size_new_i));
    assign mask_rst[e] = (J == 0 && e == 0);
  end

  always_comb begin
    mask_d = mask_q;
    if (ctrl_i.restart) begin
      mask_d = lv_init;
    end else if (ctrl_i.step) begin
      mask_d = lv_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= mask_rst;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o   = byte_q;
  assign mask_o   = mask_q;
  assign mask_d_o = mask_d;

endmodule

### hdl/bitap_approximate_matcher_top.sv
// channel | handshake                     | payload
// in      | in_valid_i / in_ready_o       | req_type_i, symbol_i
// out     | out_valid_o / out_ready_i     | error_count_o, start_position_o, match_count_o
// cfg     | cfg_we_i (no wait)            | cfg_addr_i, cfg_wdata_i
//
// One item per cycle while in_ready_o is high; each item is handled in its accept cycle.
// All error levels of one pattern position are updated inside its cell.
// A result is registered once; in_ready_o drops only while it stalls.
// Reset: empty pattern, max_errors 0, fixed_mode 1, no pending result.
module bitap_approximate_matcher_top import bam_pkg::*; #(
  parameter int MAX_PATTERN = 64,
  parameter int MAX_LEVELS  = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_addr_i,
  input  logic [ErrW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               req_type_i,
  input  logic [SymW-1:0]          symbol_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ErrW-1:0]          error_count_o,
  output logic signed [StartW-1:0] start_position_o,
  output logic [CountW-1:0]        match_count_o
);

  localparam int SW = $clog2(MAX_PATTERN + 1);
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  logic [ErrW-1:0]        max_errors_q;
  logic                   fixed_mode_q;
  logic [SW-1:0]          size_q, size_d;
  logic signed [PosW-1:0] scan_q, scan_d;
  logic [CountW-1:0]      found_q, found_d, found_inc;
  logic                   out_valid_q;
  logic [ErrW-1:0]        err_q;
  logic [StartW-1:0]      start_q;
  logic [CountW-1:0]      count_q;

  logic      accept, is_step, hit;
  logic [LW-1:0] hit_idx;
  bam_ctrl_t ctrl;

  logic [SymW-1:0]       byte_w   [MAX_PATTERN];
  logic [MAX_LEVELS-1:0] mask_w   [MAX_PATTERN];
  logic [MAX_LEVELS-1:0] mask_d_w [MAX_PATTERN];
  logic [MAX_LEVELS-1:0] nb_w     [MAX_PATTERN];
  logic [SymW-1:0]       bin_w    [MAX_PATTERN];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_step    = (req_type_i == REQ_SUBJ) || (req_type_i == REQ_PAD);

  always_comb begin
    size_d = size_q;
    if (req_type_i == REQ_CLEAR) begin
      size_d = '0;
    end else if (req_type_i == REQ_APPEND && int'(size_q) < MAX_PATTERN) begin
      size_d = size_q + SW'(1);
    end
  end

  always_comb begin
    ctrl.shift_en   = accept && req_type_i == REQ_APPEND && int'(size_q) < MAX_PATTERN;
    ctrl.restart    = accept && !is_step;
    ctrl.step       = accept && is_step;
    ctrl.pad        = req_type_i == REQ_PAD;
    ctrl.fixed_mode = fixed_mode_q;
    ctrl.symbol     = symbol_i;
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j == MAX_PATTERN - 1) begin : g_top
      assign nb_w[j] = '0;
    end else begin : g_mid
      assign nb_w[j] = mask_w[j+1];
    end
    if (j == 0) begin : g_first
      assign bin_w[j] = symbol_i;
    end else begin : g_rest
      assign bin_w[j] = byte_w[j-1];
    end

    bam_cell #(
      .J  (j),
      .NL (MAX_LEVELS),
      .SW (SW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .size_i     (size_q),
      .size_new_i (size_d),
      .byte_i     (bin_w[j]),
      .byte_o     (byte_w[j]),
      .nb_mask_i  (nb_w[j]),
      .mask_o     (mask_w[j]),
      .mask_d_o   (mask_d_w[j])
    );
  end

  // least level within max_errors whose bit 0 is clear
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int e = MAX_LEVELS - 1; e >= 0; e--) begin
      if (e <= int'(max_errors_q) && !mask_d_w[0][e]) begin
        hit     = 1'b1;
        hit_idx = LW'(e);
      end
    end
  end

  assign found_inc = (found_q < CountMax) ? found_q + CountW'(1) : found_q;

  always_comb begin
    scan_d  = scan_q;
    found_d = found_q;
    if (ctrl.restart) begin
      scan_d  = PosW'(1) - PosW'(size_d);
      found_d = '0;
    end else if (ctrl.step) begin
      if (scan_q < PosMax) begin
        scan_d = scan_q + PosW'(1);
      end
      if (hit) begin
        found_d = found_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_errors_q <= '0;
      fixed_mode_q <= 1'b1;
      size_q       <= '0;
      scan_q       <= PosW'(1);
      found_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_MAX_ERRORS: max_errors_q <= cfg_wdata_i;
          CFG_FIXED_MODE: fixed_mode_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (accept) begin
        size_q <= size_d;
      end
      scan_q  <= scan_d;
      found_q <= found_d;
      if (ctrl.step && hit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.step && hit) begin
      err_q   <= ErrW'(hit_idx);
      start_q <= scan_q[StartW-1:0];
      count_q <= found_inc;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign error_count_o    = err_q;
  assign start_position_o = start_q;
  assign match_count_o    = count_q;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == REQ_CLEAR |=> size_q == '0)
    else $error("pattern not emptied by clear");

  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.restart |=> found_q == '0)
    else $error("match count survives pattern change");

  a_hit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step && hit |=> out_valid_o && match_count_o == found_q)
    else $error("result lost or count mismatch");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |=> found_q >= $past(found_q))
    else $error("match count dropped on step");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(size_q) <= MAX_PATTERN)
    else $error("pattern size overflow");

endmodule
